/* rtl/itp_pkg.sv */
// Shared types, character codes, stack codes and lookup functions for the infix to postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef logic [7:0] char_t;
	typedef logic [1:0] status_t;
	typedef logic [2:0] code_t;

	localparam code_t CODE_NONE  = 3'd0;
	localparam code_t CODE_OPEN  = 3'd1;
	localparam code_t CODE_PLUS  = 3'd2;
	localparam code_t CODE_MINUS = 3'd3;
	localparam code_t CODE_MUL   = 3'd4;
	localparam code_t CODE_DIV   = 3'd5;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_OPEN  = 8'h28;
	localparam char_t CH_CLOSE = 8'h29;
	localparam char_t CH_MUL   = 8'h2A;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DIV   = 8'h2F;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	localparam status_t ST_OK              = 2'd0;
	localparam status_t ST_OVERFLOW        = 2'd1;
	localparam status_t ST_UNMATCHED_CLOSE = 2'd2;
	localparam status_t ST_UNMATCHED_OPEN  = 2'd3;

	function automatic code_t char_code(char_t c);
		code_t r;
		unique case (c)
			CH_OPEN:  r = CODE_OPEN;
			CH_PLUS:  r = CODE_PLUS;
			CH_MINUS: r = CODE_MINUS;
			CH_MUL:   r = CODE_MUL;
			CH_DIV:   r = CODE_DIV;
			default:  r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic char_t code_char(code_t c);
		char_t r;
		unique case (c)
			CODE_OPEN:  r = CH_OPEN;
			CODE_PLUS:  r = CH_PLUS;
			CODE_MINUS: r = CH_MINUS;
			CODE_MUL:   r = CH_MUL;
			CODE_DIV:   r = CH_DIV;
			default:    r = CH_NUL;
		endcase
		return r;
	endfunction

	function automatic logic prec_hi(code_t c);
		return (c >= CODE_MUL);
	endfunction

endpackage

/* rtl/itp_in_if.sv */
// Input channel interface: one infix character word with its end mark.
`timescale 1ns / 1ps

interface itp_in_if import itp_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t in_char;
	logic  in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink (input valid, input in_char, input in_last, output ready);
endinterface

/* rtl/itp_out_if.sv */
// Output channel interface: one postfix result word with end marks and status.
`timescale 1ns / 1ps

interface itp_out_if import itp_pkg::*; ();
	logic    valid;
	logic    ready;
	char_t   out_char;
	logic    out_last;
	logic    expr_done;
	status_t status;

	modport source (output valid, output out_char, output out_last, output expr_done,
		output status, input ready);
	modport sink (input valid, input out_char, input out_last, input expr_done,
		input status, output ready);
endinterface

/* rtl/infix_to_postfix_converter.sv */
// Shunting-yard infix to postfix converter with an operator stack in synchronous RAM.
//
//  channel   dir   word                                   handshake
//  infix     in    in_char[8], in_last                    valid/ready
//  postfix   out   out_char[8], out_last, expr_done,      valid/ready
//                  status[2]
//
// An item passes through accept, decode and finish; a push adds a push step. A stack walk (close, operator,
// final flush) adds a fetch and an evaluate step per entry read (the RAM read is registered)
// and one fetch when it meets the bottom; the final item adds its flush walk.
// Each result is staged one word behind so the end marks can be set on it.
// Output stalls hold the sequencer only when a new result needs the output register.
// Reset is asynchronous; the stack RAM needs no clearing, only entries below the count are read.
`timescale 1ns / 1ps

module infix_to_postfix_converter import itp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	itp_in_if.sink    infix,
	itp_out_if.source postfix
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_EVAL   = 3'd3;
	localparam logic [2:0] S_PUSH   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	localparam logic [1:0] M_CLOSE = 2'd0;
	localparam logic [1:0] M_OP    = 2'd1;
	localparam logic [1:0] M_FLUSH = 2'd2;

	logic [2:0]       state_q, state_d;
	logic [1:0]       mode_q, mode_d;
	char_t            ch_q;
	logic             last_q;
	code_t            code_q;
	logic             latch_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_dec;

	logic             pend_valid_q;
	char_t            pend_char_q;
	status_t          pend_status_q;

	logic             out_valid_q;
	char_t            out_char_q;
	logic             out_last_q;
	logic             out_done_q;
	status_t          out_status_q;

	code_t            mem [STACK_DEPTH];
	code_t            rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic    accept, slot_free, can_emit, at_bottom, full, is_digit;
	logic    emit, pop, push, raise, fin_load, out_load;
	char_t   emit_char;
	status_t emit_status;

	assign accept    = infix.valid && infix.ready;
	assign slot_free = !out_valid_q || postfix.ready;
	assign can_emit  = !pend_valid_q || slot_free;
	assign at_bottom = (count_q == '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign is_digit  = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
	assign count_dec = count_q - 1'b1;
	assign rd_addr   = count_dec[ADDR_W-1:0];

	assign fin_load = (state_q == S_FIN) && slot_free && (pend_valid_q || last_q);
	assign out_load = (emit && pend_valid_q) || fin_load;

	assign infix.ready       = (state_q == S_IDLE);
	assign postfix.valid     = out_valid_q;
	assign postfix.out_char  = out_char_q;
	assign postfix.out_last  = out_last_q;
	assign postfix.expr_done = out_done_q;
	assign postfix.status    = out_status_q;

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		emit        = 1'b0;
		emit_char   = CH_NUL;
		emit_status = ST_OK;
		pop         = 1'b0;
		push        = 1'b0;
		raise       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !latch_q) state_d = S_DECODE;
			end
			S_DECODE: begin
				mode_d = M_FLUSH;
				priority if (is_digit) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_char = ch_q;
						state_d   = last_q ? S_FETCH : S_FIN;
					end
				end else if (ch_q == CH_CLOSE) begin
					mode_d  = M_CLOSE;
					state_d = S_FETCH;
				end else if (code_q == CODE_OPEN) begin
					state_d = S_PUSH;
				end else if (code_q != CODE_NONE) begin
					mode_d  = M_OP;
					state_d = S_FETCH;
				end else begin
					state_d = last_q ? S_FETCH : S_FIN;
				end
			end
			S_FETCH: begin
				if (at_bottom) begin
					unique case (mode_q)
						M_CLOSE: begin
							if (can_emit) begin
								emit        = 1'b1;
								emit_status = ST_UNMATCHED_CLOSE;
								raise       = 1'b1;
								state_d     = S_FIN;
							end
						end
						M_OP:    state_d = S_PUSH;
						default: state_d = S_FIN;
					endcase
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				unique case (mode_q)
					M_CLOSE: begin
						if (rd_q == CODE_OPEN) begin
							pop     = 1'b1;
							mode_d  = M_FLUSH;
							state_d = last_q ? S_FETCH : S_FIN;
						end else if (can_emit) begin
							emit      = 1'b1;
							emit_char = code_char(rd_q);
							pop       = 1'b1;
							state_d   = S_FETCH;
						end
					end
					M_OP: begin
						if (rd_q == CODE_OPEN || (!prec_hi(rd_q) && prec_hi(code_q))) begin
							state_d = S_PUSH;
						end else if (can_emit) begin
							emit      = 1'b1;
							emit_char = code_char(rd_q);
							pop       = 1'b1;
							state_d   = S_FETCH;
						end
					end
					default: begin
						if (can_emit) begin
							emit = 1'b1;
							if (rd_q == CODE_OPEN) begin
								emit_status = ST_UNMATCHED_OPEN;
								raise       = 1'b1;
								state_d     = S_FIN;
							end else begin
								emit_char = code_char(rd_q);
								pop       = 1'b1;
								state_d   = S_FETCH;
							end
						end
					end
				endcase
			end
			S_PUSH: begin
				mode_d = M_FLUSH;
				if (full) begin
					if (can_emit) begin
						emit        = 1'b1;
						emit_status = ST_OVERFLOW;
						raise       = 1'b1;
						state_d     = S_FIN;
					end
				end else begin
					push    = 1'b1;
					state_d = last_q ? S_FETCH : S_FIN;
				end
			end
			S_FIN: begin
				if (!(pend_valid_q || last_q) || slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_FLUSH;
			latch_q      <= 1'b0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;

			if (accept && latch_q && infix.in_last) latch_q <= 1'b0;

			priority if (raise) count_q <= '0;
			else if (pop)       count_q <= count_dec;
			else if (push)      count_q <= count_q + 1'b1;

			if (raise) latch_q <= 1'b1;

			if (emit) pend_valid_q <= 1'b1;
			else if (fin_load) pend_valid_q <= 1'b0;

			if (state_q == S_FIN && state_d == S_IDLE && last_q) begin
				latch_q <= 1'b0;
				count_q <= '0;
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (postfix.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= infix.in_char;
			last_q <= infix.in_last;
			code_q <= char_code(infix.in_char);
		end
		if (emit) begin
			pend_char_q   <= emit_char;
			pend_status_q <= emit_status;
		end
		if (emit && pend_valid_q) begin
			out_char_q   <= pend_char_q;
			out_status_q <= pend_status_q;
			out_last_q   <= 1'b0;
			out_done_q   <= 1'b0;
		end else if (fin_load) begin
			out_last_q <= 1'b1;
			out_done_q <= last_q;
			if (pend_valid_q) begin
				out_char_q   <= pend_char_q;
				out_status_q <= pend_status_q;
			end else begin
				out_char_q   <= CH_NUL;
				out_status_q <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[count_q[ADDR_W-1:0]] <= code_q;
		rd_q <= mem[rd_addr];
	end

endmodule

/* tb/infix_to_postfix_converter_tb.sv */
// Self-checking testbench for the infix to postfix converter: directed table, then random expressions.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
	import itp_pkg::*;

	typedef struct packed {
		char_t   ch;
		logic    last;
		logic    done;
		status_t st;
	} postfix_word_t;

	typedef struct packed {
		char_t         ch;
		logic          last;
		logic [4:0]    rep;
		logic          typed;
		postfix_word_t exp;
	} stim_row_t;

	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_CARET = 8'h5E;
	localparam char_t CH_ONES  = 8'hFF;

	localparam int RAND_WORDS  = 420;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN       = 60;
	localparam int IDLE_PCT    = 23;

	localparam postfix_word_t NO_WORD = '0;

	localparam int N_ROWS = 21;
	localparam stim_row_t DIR_TAB [N_ROWS] = '{
		'{CH_NINE,  1'b1, 5'd1,  1'b1, '{CH_NINE, 1'b1, 1'b1, ST_OK}},
		'{CH_ZERO,  1'b0, 5'd1,  1'b1, '{CH_ZERO, 1'b1, 1'b0, ST_OK}},
		'{CH_PLUS,  1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_NINE,  1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_MUL,   1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_OPEN,  1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_NUL,   1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_MINUS, 1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_DIV,   1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_CLOSE, 1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_MINUS, 1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_ONES,  1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_CARET, 1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_CLOSE, 1'b1, 5'd1,  1'b0, NO_WORD},
		'{CH_CLOSE, 1'b1, 5'd1,  1'b1, '{CH_NUL, 1'b1, 1'b1, ST_UNMATCHED_CLOSE}},
		'{CH_OPEN,  1'b1, 5'd1,  1'b1, '{CH_NUL, 1'b1, 1'b1, ST_UNMATCHED_OPEN}},
		'{CH_SPACE, 1'b1, 5'd1,  1'b1, '{CH_NUL, 1'b1, 1'b1, ST_OK}},
		'{CH_OPEN,  1'b0, 5'd16, 1'b0, NO_WORD},
		'{CH_OPEN,  1'b0, 5'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, ST_OVERFLOW}},
		'{CH_NINE,  1'b0, 5'd1,  1'b0, NO_WORD},
		'{CH_PLUS,  1'b1, 5'd1,  1'b0, NO_WORD}
	};

	logic clk;
	logic arst_n;

	itp_in_if  infix ();
	itp_out_if postfix ();

	infix_to_postfix_converter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.infix  (infix),
		.postfix(postfix)
	);

	// operator stack mirror
	code_t       op_stk [STACK_DEPTH];
	int unsigned stk_cnt;
	logic        err_hold;

	postfix_word_t word_q [$];
	logic          drv_typed;
	postfix_word_t drv_exp;

	int fail_cnt    = 0;
	int idle_cycles = 0;
	int n_in        = 0;
	int n_sent      = 0;
	int n_words     = 0;
	int n_expr      = 0;
	int n_status [4] = '{0, 0, 0, 0};

	wire calm = (n_in >= 150) && (n_in < 250);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic char_t op_glyph(code_t c);
		char_t g;
		case (c)
			CODE_OPEN:  g = CH_OPEN;
			CODE_PLUS:  g = CH_PLUS;
			CODE_MINUS: g = CH_MINUS;
			CODE_MUL:   g = CH_MUL;
			CODE_DIV:   g = CH_DIV;
			default:    g = CH_NUL;
		endcase
		return g;
	endfunction

	function automatic logic is_high(code_t c);
		return (c == CODE_MUL) || (c == CODE_DIV);
	endfunction

	function automatic void put_word(ref postfix_word_t q[$], input char_t c, input status_t s);
		postfix_word_t w;
		w = '{c, 1'b0, 1'b0, s};
		q.push_back(w);
	endfunction

	function automatic void stack_fault(ref postfix_word_t q[$], input status_t s);
		stk_cnt  = 0;
		err_hold = 1'b1;
		put_word(q, CH_NUL, s);
	endfunction

	// one input word through the shunting-yard step
	function automatic void shunt(input char_t c, input logic last, ref postfix_word_t q[$]);
		code_t cd;
		logic  failed;
		logic  stop;
		failed = 1'b0;
		if (err_hold) begin
			if (last)
				err_hold = 1'b0;
			return;
		end
		case (c)
			CH_OPEN:  cd = CODE_OPEN;
			CH_PLUS:  cd = CODE_PLUS;
			CH_MINUS: cd = CODE_MINUS;
			CH_MUL:   cd = CODE_MUL;
			CH_DIV:   cd = CODE_DIV;
			default:  cd = CODE_NONE;
		endcase
		if (c >= CH_ZERO && c <= CH_NINE) begin
			put_word(q, c, ST_OK);
		end else if (c == CH_CLOSE) begin
			stop = 1'b0;
			while (!stop) begin
				if (stk_cnt == 0) begin
					stack_fault(q, ST_UNMATCHED_CLOSE);
					failed = 1'b1;
					stop   = 1'b1;
				end else begin
					stk_cnt--;
					if (op_stk[stk_cnt] == CODE_OPEN)
						stop = 1'b1;
					else
						put_word(q, op_glyph(op_stk[stk_cnt]), ST_OK);
				end
			end
		end else if (cd != CODE_NONE) begin
			if (cd != CODE_OPEN) begin
				while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CODE_OPEN &&
						is_high(op_stk[stk_cnt - 1]) >= is_high(cd)) begin
					stk_cnt--;
					put_word(q, op_glyph(op_stk[stk_cnt]), ST_OK);
				end
			end
			if (stk_cnt >= STACK_DEPTH) begin
				stack_fault(q, ST_OVERFLOW);
				failed = 1'b1;
			end else begin
				op_stk[stk_cnt] = cd;
				stk_cnt++;
			end
		end
		if (last) begin
			if (!failed) begin
				stop = 1'b0;
				while (stk_cnt > 0 && !stop) begin
					stk_cnt--;
					if (op_stk[stk_cnt] == CODE_OPEN) begin
						stack_fault(q, ST_UNMATCHED_OPEN);
						stop = 1'b1;
					end else begin
						put_word(q, op_glyph(op_stk[stk_cnt]), ST_OK);
					end
				end
				if (q.size() == 0)
					put_word(q, CH_NUL, ST_OK);
			end
			err_hold = 1'b0;
			stk_cnt  = 0;
			q[q.size() - 1].done = 1'b1;
		end
		if (q.size() > 0)
			q[q.size() - 1].last = 1'b1;
	endfunction

	function automatic char_t pick_op();
		char_t c;
		case ($urandom_range(0, 3))
			0:       c = CH_PLUS;
			1:       c = CH_MINUS;
			2:       c = CH_MUL;
			default: c = CH_DIV;
		endcase
		return c;
	endfunction

	function automatic char_t pick_digit();
		return char_t'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic void build_expr(ref char_t seq[$], input int lvl);
		int terms;
		terms = $urandom_range(1, 3);
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				seq.push_back(pick_op());
			if (lvl < 6 && $urandom_range(0, 3) == 0) begin
				seq.push_back(CH_OPEN);
				build_expr(seq, lvl + 1);
				seq.push_back(CH_CLOSE);
			end else begin
				seq.push_back(pick_digit());
			end
		end
	endfunction

	task automatic send_word(input char_t c, input logic last, input logic typed,
			input postfix_word_t exp);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			infix.valid <= 1'b0;
			@(negedge clk);
		end
		infix.valid   <= 1'b1;
		infix.in_char <= c;
		infix.in_last <= last;
		drv_typed = typed;
		drv_exp   = exp;
		@(posedge clk);
		while (!infix.ready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic report_field(input string fname, input int unsigned expv,
			input int unsigned actv);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, expv, actv);
		fail_cnt++;
	endtask

	always @(negedge clk)
		postfix.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	// output check first, then prediction of the word accepted at the same edge
	always @(posedge clk) begin
		postfix_word_t got;
		postfix_word_t want;
		postfix_word_t scratch [$];
		logic          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (postfix.valid && postfix.ready) begin
				moved = 1'b1;
				got = '{postfix.out_char, postfix.out_last, postfix.expr_done, postfix.status};
				n_words++;
				if (!$isunknown(got.st))
					n_status[got.st]++;
				if (word_q.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual %h", $time, got);
					fail_cnt++;
				end else begin
					want = word_q.pop_front();
					if (got.ch !== want.ch)
						report_field("out_char", want.ch, got.ch);
					if (got.last !== want.last)
						report_field("out_last", want.last, got.last);
					if (got.done !== want.done)
						report_field("expr_done", want.done, got.done);
					if (got.st !== want.st)
						report_field("status", want.st, got.st);
				end
			end
			if (infix.valid && infix.ready) begin
				moved = 1'b1;
				scratch.delete();
				shunt(infix.in_char, infix.in_last, scratch);
				if (infix.in_last)
					n_expr++;
				if (drv_typed)
					word_q.push_back(drv_exp);
				else
					foreach (scratch[k])
						word_q.push_back(scratch[k]);
				n_in++;
			end
		end
		idle_cycles <= moved ? 0 : idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("infix_to_postfix_converter test failed");
		$finish;
	end

	initial begin
		char_t seq [$];
		int    kind;
		int    pos;
		int    nest;
		arst_n        = 1'b0;
		infix.valid   = 1'b0;
		infix.in_char = CH_NUL;
		infix.in_last = 1'b0;
		postfix.ready = 1'b0;
		drv_typed     = 1'b0;
		drv_exp       = NO_WORD;
		stk_cnt       = 0;
		err_hold      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < N_ROWS; r++)
			for (int k = 0; k < DIR_TAB[r].rep; k++)
				send_word(DIR_TAB[r].ch, DIR_TAB[r].last, DIR_TAB[r].typed, DIR_TAB[r].exp);

		pos = n_sent;
		while (n_sent < pos + RAND_WORDS) begin
			seq.delete();
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				build_expr(seq, 0);
				if ($urandom_range(0, 2) == 0)
					seq.insert($urandom_range(0, seq.size()), char_t'($urandom_range(0, 255)));
			end else if (kind < 77) begin
				// deep nesting, can run into the stack limit
				nest = $urandom_range(10, 18);
				for (int i = 0; i < nest; i++) begin
					seq.push_back(CH_OPEN);
					if ($urandom_range(0, 1)) begin
						seq.push_back(pick_digit());
						seq.push_back(pick_op());
					end
				end
				seq.push_back(pick_digit());
				for (int i = 0; i < nest; i++)
					seq.push_back(CH_CLOSE);
			end else if (kind < 92) begin
				build_expr(seq, 0);
				case ($urandom_range(0, 3))
					0: seq.delete($urandom_range(0, seq.size() - 1));
					1: seq.insert($urandom_range(0, seq.size()), CH_OPEN);
					2: seq.insert($urandom_range(0, seq.size()), CH_CLOSE);
					default: seq[$urandom_range(0, seq.size() - 1)] = char_t'($urandom_range(0, 255));
				endcase
			end else begin
				nest = $urandom_range(1, 6);
				for (int i = 0; i < nest; i++)
					seq.push_back(char_t'($urandom_range(0, 255)));
			end
			if (seq.size() == 0)
				seq.push_back(pick_digit());
			foreach (seq[i])
				send_word(seq[i], i == seq.size() - 1, 1'b0, NO_WORD);
		end

		@(negedge clk);
		infix.valid <= 1'b0;
		while (word_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d input words in %0d expressions, checked %0d postfix words.",
			n_in, n_expr, n_words);
		$display("Error words seen: overflow %0d, unmatched close %0d, unmatched open %0d.",
			n_status[ST_OVERFLOW], n_status[ST_UNMATCHED_CLOSE], n_status[ST_UNMATCHED_OPEN]);
		if (fail_cnt == 0 && word_q.size() == 0) begin
			$display("infix_to_postfix_converter test passed");
		end else begin
			$display("infix_to_postfix_converter test failed");
		end
		$finish;
	end

endmodule
